@@ hdl/mtfl_pkg.sv @@
// ----------------------------------------------------------------------------
// mtfl_pkg: shared types and constants for the move-to-front list
// Field widths, command codes and the control bundle driven into every cell.
// ----------------------------------------------------------------------------
package mtfl_pkg;

	// Beat field widths
	localparam int KEY_W   = 64;
	localparam int RANK_W  = 4;
	localparam int COUNT_W = 5;

	// Command kinds
	localparam logic KIND_TOUCH = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Control broadcast to the cell row
	typedef struct packed {
		logic cmp_en;   // compare phase: capture per-cell match
		logic upd_en;   // update phase: shift enabled cells
		logic touch;    // current command reorders the list
		logic hit;      // key was found in compare phase
	} cell_ctl_t;

endpackage

@@ hdl/mtfl_cell.sv @@
// ----------------------------------------------------------------------------
// mtfl_cell: one entry of the move-to-front list
// Holds one key, compares it against the command key and takes its
// upstream neighbor's key when the list shifts down.
// ----------------------------------------------------------------------------
module mtfl_cell #(
	parameter int KEY_WIDTH = 64
) (
	input  logic                   clk,
	input  mtfl_pkg::cell_ctl_t    ctl,
	input  logic [KEY_WIDTH-1:0]   cmd_key,
	input  logic [KEY_WIDTH-1:0]   prev_key,
	input  logic                   valid,
	input  logic                   fill,
	input  logic                   seen_in,
	output logic [KEY_WIDTH-1:0]   key_o,
	output logic                   match,
	output logic                   seen_out,
	output logic                   first
);
	import mtfl_pkg::*;

	logic [KEY_WIDTH-1:0] key_q;
	logic                 match_s1;
	logic                 shift;

	// compare against the command key
	assign match = valid && (key_q == cmd_key);

	// match found in this cell or any cell nearer the front
	assign seen_out = seen_in | match_s1;
	assign first    = match_s1 & ~seen_in;

	// hit: cells up to the hit rank move; miss: cells up to the new tail move
	assign shift = ctl.upd_en && ctl.touch && (ctl.hit ? !seen_in : fill);

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			match_s1 <= match;
		end
		if (shift) begin
			key_q <= prev_key;
		end
	end

	assign key_o = key_q;

endmodule

@@ hdl/mru_move_to_front_list.sv @@
// ----------------------------------------------------------------------------
// mru_move_to_front_list: most-recently-used key list, newest at rank 0
// Result strobe done is registered after the compare cycle and the update cycle.
// A new command is accepted in the update cycle; compare cycle, then update cycle
// through the cell row (the next compare needs the reordered list).
// Reset clears the entry count and the sequencer; keys are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module mru_move_to_front_list #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [mtfl_pkg::KEY_W-1:0]    key,
	output logic                          done,
	output logic                          found,
	output logic [mtfl_pkg::RANK_W-1:0]   rank,
	output logic [mtfl_pkg::COUNT_W-1:0]  count
);
	import mtfl_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);

	logic                 accept;
	logic                 cmp_q;
	logic                 upd_q;
	logic                 kind_q;
	logic [KEY_WIDTH-1:0] ckey_q;
	logic                 hit_s1;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_next;
	logic                 done_q;
	logic                 found_q;
	logic [RANK_W-1:0]    rank_q;
	logic [COUNT_W-1:0]   count_q;
	logic [PW-1:0]        pos;
	logic [31:0]          pos32;
	logic [31:0]          cnt32;
	cell_ctl_t            ctl;

	logic [KEY_WIDTH-1:0] cell_key [DEPTH];
	logic [DEPTH-1:0]     cell_match;
	logic [DEPTH-1:0]     cell_first;
	logic [DEPTH:0]       seen;

	// command beat accepted when idle or in the update cycle
	assign busy   = cmp_q;
	assign accept = start & ~busy;

	// cell control bundle
	assign ctl.cmp_en = cmp_q;
	assign ctl.upd_en = upd_q;
	assign ctl.touch  = (kind_q == KIND_TOUCH);
	assign ctl.hit    = hit_s1;

	// cell row, rank 0 first
	assign seen[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] prev;
		if (i == 0) begin : g_front
			assign prev = ckey_q;
		end else begin : g_rest
			assign prev = cell_key[i-1];
		end
		mtfl_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.cmd_key  (ckey_q),
			.prev_key (prev),
			.valid    (CW'(i) < cnt_q),
			.fill     (CW'(i) <= cnt_q),
			.seen_in  (seen[i]),
			.key_o    (cell_key[i]),
			.match    (cell_match[i]),
			.seen_out (seen[i+1]),
			.first    (cell_first[i])
		);
	end

	// rank of the first match (at most one first flag is set)
	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_first[i]) begin
				pos = pos | PW'(i);
			end
		end
	end
	assign pos32 = 32'(pos);

	// entry count after this command
	always_comb begin
		cnt_next = cnt_q;
		if (kind_q == KIND_TOUCH && !hit_s1 && cnt_q < CW'(DEPTH)) begin
			cnt_next = cnt_q + CW'(1);
		end
	end
	assign cnt32 = 32'(cnt_next);

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q  <= 1'b0;
			upd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			cmp_q  <= accept;
			upd_q  <= cmp_q;
			done_q <= upd_q;
			if (upd_q) begin
				cnt_q <= cnt_next;
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			ckey_q <= key[KEY_WIDTH-1:0];
		end
		if (cmp_q) begin
			hit_s1 <= |cell_match;
		end
		if (upd_q) begin
			found_q <= hit_s1;
			rank_q  <= hit_s1 ? pos32[RANK_W-1:0] : '0;
			count_q <= cnt32[COUNT_W-1:0];
		end
	end

	assign done  = done_q;
	assign found = found_q;
	assign rank  = rank_q;
	assign count = count_q;

endmodule
